// ===== rtl/core/ssfc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssfc_pkg
// Shared types and constants for the servo status frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ssfc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 9;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] MIN_LENGTH  = 8'd2;
    // last body byte sits at position length + 2
    localparam logic [POS_W-1:0]  BODY_END_OFS = 9'd2;
    localparam logic [POS_W-1:0]  LENGTH_POS   = 9'd3;

    // parser phase: which part of the frame comes next
    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_ID   = 3'd2,
        PH_LEN  = 3'd3,
        PH_BODY = 3'd4,
        PH_CSUM = 3'd5
    } t_phase;

    // frame status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_HEADER = 2'd1,
        ST_CSUM   = 2'd2,
        ST_LENGTH = 2'd3
    } t_status;

    // one result per received byte
    typedef struct packed {
        logic [BYTE_W-1:0] echo_byte;
        logic [POS_W-1:0]  byte_position;
        logic              frame_done;
        t_status           frame_status;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/ssfc_parser.sv =====
// ----------------------------------------------------------------------------
// ssfc_parser
// Frame parse state and the per-byte step: header, id, length, body and
// checksum checks, producing one result for every byte processed.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfc_parser
    import ssfc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_byte,
    output t_result                o_result
);

    t_phase            r_phase, n_phase;
    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [BYTE_W-1:0] r_sum,   n_sum;
    logic [BYTE_W-1:0] r_len,   n_len;

    logic [POS_W-1:0]  pos;
    logic              done;
    t_status           status;
    logic [POS_W-1:0]  body_end;

    assign body_end = {1'b0, r_len} + BODY_END_OFS;

    // next state and result for the current byte
    always_comb begin
        pos     = r_pos;
        done    = 1'b0;
        status  = ST_OK;
        n_phase = r_phase;
        n_sum   = r_sum;
        n_len   = r_len;

        unique case (r_phase)
            PH_HDR2: begin
                if (i_byte != HEADER_BYTE) begin
                    done   = 1'b1;
                    status = ST_HEADER;
                end else begin
                    n_phase = PH_ID;
                end
            end
            PH_ID: begin
                n_sum   = i_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                if (i_byte < MIN_LENGTH) begin
                    done   = 1'b1;
                    status = ST_LENGTH;
                end else begin
                    n_len   = i_byte;
                    n_sum   = r_sum + i_byte;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_sum = r_sum + i_byte;
                if (r_pos >= body_end) begin
                    n_phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                done   = 1'b1;
                // 255 - sum is the bitwise complement on 8 bits
                status = (i_byte == ~r_sum) ? ST_OK : ST_CSUM;
            end
            default: begin
                // first header byte, also any undefined phase code
                pos = '0;
                if (i_byte != HEADER_BYTE) begin
                    done   = 1'b1;
                    status = ST_HEADER;
                end else begin
                    n_phase = PH_HDR2;
                end
            end
        endcase

        if (done) begin
            n_phase = PH_HDR1;
            n_pos   = '0;
            n_sum   = '0;
            n_len   = '0;
        end else begin
            n_pos = pos + 1'b1;
        end
    end

    assign o_result.echo_byte     = i_byte;
    assign o_result.byte_position = pos;
    assign o_result.frame_done    = done;
    assign o_result.frame_status  = status;

    // parse state register, advances once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR1;
            r_pos   <= '0;
            r_sum   <= '0;
            r_len   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_len   <= n_len;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/servo_status_frame_checker.sv =====
// ----------------------------------------------------------------------------
// servo_status_frame_checker
// Checks a servo status frame byte by byte and reports each byte's position
// and, at the frame end or an abort, the frame status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_rx_valid / o_rx_stall / i_rx_byte) takes one received
//   byte per request. Output channel (o_res_valid / i_res_stall and the
//   o_* result fields) gives exactly one result per byte, in order.
//   A frame is FF FF, id, length, length-1 bytes, checksum. The result at
//   the closing byte or at a failure has o_frame_done set and o_frame_status
//   0 ok, 1 wrong header, 2 wrong checksum, 3 bad length; then the block
//   waits for a new header.
//   A byte accepted passes the input register, then the result register,
//   with a combinational parse step between them. Throughput: one byte per
//   cycle while the receiver does not stall.
//   When the receiver stalls, the result holds; if the input register is
//   empty, one more byte is taken into it, after which o_rx_stall rises
//   until the result moves. Reset (synchronous, active low) empties both
//   registers and returns the parser to waiting for the first header byte.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_status_frame_checker
    import ssfc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // byte input channel
    input  wire logic              i_rx_valid,
    output logic                   o_rx_stall,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    // result channel
    output logic                   o_res_valid,
    input  wire logic              i_res_stall,
    output logic [BYTE_W-1:0]      o_echo_byte,
    output logic [POS_W-1:0]       o_byte_position,
    output logic                   o_frame_done,
    output logic [1:0]             o_frame_status
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           step_result;
    logic              out_load;
    logic              in_load;

    // elastic handshake across the two stages
    assign out_load   = !r_out_valid || !i_res_stall;
    assign in_load    = !r_in_valid || out_load;
    assign o_rx_stall = !in_load;

    ssfc_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_in_valid && out_load),
        .i_byte   (r_in_byte),
        .o_result (step_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_out <= step_result;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_echo_byte     = r_out.echo_byte;
    assign o_byte_position = r_out.byte_position;
    assign o_frame_done    = r_out.frame_done;
    assign o_frame_status  = r_out.frame_status;

endmodule

`default_nettype wire

// ===== rtl/core/ssfc_checker.sv =====
// ----------------------------------------------------------------------------
// ssfc_checker
// Port-level assertions for the servo status frame checker, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfc_checker
    import ssfc_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_res_valid,
    input wire logic              i_res_stall,
    input wire logic [BYTE_W-1:0] i_echo_byte,
    input wire logic [POS_W-1:0]  i_byte_position,
    input wire logic              i_frame_done,
    input wire logic [1:0]        i_frame_status
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_stall |=> i_res_valid && $stable(i_echo_byte)
            && $stable(i_byte_position) && $stable(i_frame_done)
            && $stable(i_frame_status))
        else $error("result changed while stalled");

    // status is only reported at the frame end
    a_status_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_frame_done |-> i_frame_status == ST_OK)
        else $error("status set without frame end");

    // a frame only continues past position 0 on a header byte
    a_hdr_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_byte_position == '0 && !i_frame_done
            |-> i_echo_byte == HEADER_BYTE)
        else $error("frame started without header byte");

    // header failures only at the two header positions
    a_hdr_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_frame_done && i_frame_status == ST_HEADER
            |-> i_byte_position <= 9'd1)
        else $error("header error outside header");

    // bad length only at the length byte, with a short length
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_frame_done && i_frame_status == ST_LENGTH
            |-> i_byte_position == LENGTH_POS && i_echo_byte < MIN_LENGTH)
        else $error("bad length reported wrongly");

endmodule

bind servo_status_frame_checker ssfc_checker u_ssfc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res_valid),
    .i_res_stall     (i_res_stall),
    .i_echo_byte     (o_echo_byte),
    .i_byte_position (o_byte_position),
    .i_frame_done    (o_frame_done),
    .i_frame_status  (o_frame_status)
);

`default_nettype wire
